// ----- design/rgba_rld_pkg.sv -----
// ----------------------------------------------------------------------------
// rgba_rld_pkg
// Shared types and constants of the RGBA run-length decoder.
// ----------------------------------------------------------------------------
package rgba_rld_pkg;

  // widths of counters, limits and fields
  localparam int CNT_W    = 25;
  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 32;
  localparam int REPEAT_W = 9;
  localparam int STATUS_W = 2;
  localparam int ADDR_W   = 2;

  // largest legal limits
  localparam logic [CNT_W-1:0] MAX_STREAM_BYTES = 25'h100_0000;
  localparam logic [CNT_W-1:0] MAX_PIXELS       = 25'h100_0000;

  // alpha of opaque runs
  localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // configuration register indexes
  localparam logic [ADDR_W-1:0] REG_CONTROL_LENGTH  = 2'd0;
  localparam logic [ADDR_W-1:0] REG_DATA_LENGTH     = 2'd1;
  localparam logic [ADDR_W-1:0] REG_OUT_PIXEL_LIMIT = 2'd2;

  // decoder phase
  typedef enum logic [1:0] {
    PH_OPCODE = 2'd0,
    PH_LENGTH = 2'd1,
    PH_DATA   = 2'd2
  } phase_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_WRONG_STREAM = 2'd1,
    ST_PAST_LIMIT   = 2'd2,
    ST_CLIPPED      = 2'd3
  } status_t;

endpackage

// ----- design/rgba_rld_in_if.sv -----
// ----------------------------------------------------------------------------
// rgba_rld_in_if
// Input byte channel: one tagged byte per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rgba_rld_in_if import rgba_rld_pkg::*; ();

  logic              valid;
  logic              ready;
  logic              from_data_stream;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output from_data_stream, output in_byte, input ready);
  modport sink   (input valid, input from_data_stream, input in_byte, output ready);

endinterface

// ----- design/rgba_rld_out_if.sv -----
// ----------------------------------------------------------------------------
// rgba_rld_out_if
// Result channel: one decoded result per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rgba_rld_out_if import rgba_rld_pkg::*; ();

  logic                valid;
  logic                ready;
  logic                pixel_valid;
  logic [WORD_W-1:0]   pixel_word;
  logic [REPEAT_W-1:0] repeat_count;
  logic                next_from_data;
  logic [STATUS_W-1:0] status;
  logic                finished;

  modport source (output valid, output pixel_valid, output pixel_word, output repeat_count,
                  output next_from_data, output status, output finished, input ready);
  modport sink   (input valid, input pixel_valid, input pixel_word, input repeat_count,
                  input next_from_data, input status, input finished, output ready);

endinterface

// ----- design/rgba_run_length_decoder.sv -----
// ----------------------------------------------------------------------------
// rgba_run_length_decoder
// Decodes tagged control and colour bytes into RGBA pixels and pixel runs.
// ----------------------------------------------------------------------------
// Each accepted byte yields exactly one result item. The decoder takes one
// byte per cycle: the phase and counter update and the result are computed in
// the same cycle from the byte and the state registers, and the result lands
// in an output register, so a new byte is accepted whenever that register is
// empty or is being drained. The result is valid in the cycle after its byte is accepted.
// Transparent runs leave as a single result with a repeat count; opaque runs
// leave one pixel per three data bytes. Limits are set through the cfg_ port
// (values above 2^24 are clamped) and must be written while the block is idle.
// ----------------------------------------------------------------------------
module rgba_run_length_decoder import rgba_rld_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [ADDR_W-1:0]  cfg_addr,
  input  logic [CNT_W-1:0]   cfg_wdata,
  rgba_rld_in_if.sink        in_chan,
  rgba_rld_out_if.source     out_chan
);

  // configuration registers
  logic [CNT_W-1:0] control_length_r, data_length_r, out_pixel_limit_r;

  // decoder state
  phase_t              phase_r, phase_nxt;
  logic                run_is_opaque_r, run_is_opaque_nxt;
  logic [REPEAT_W-1:0] pixels_left_r, pixels_left_nxt;
  logic [1:0]          byte_in_pixel_r, byte_in_pixel_nxt;
  logic [15:0]         colour_r, colour_nxt;
  logic [BYTE_W-1:0]   alpha_r, alpha_nxt;
  logic [CNT_W-1:0]    control_used_r, control_used_nxt;
  logic [CNT_W-1:0]    data_used_r, data_used_nxt;
  logic [CNT_W-1:0]    pixels_written_r, pixels_written_nxt;

  // result register
  logic                out_valid_r;
  logic                pixel_valid_r, pixel_valid_nxt;
  logic [WORD_W-1:0]   pixel_word_r, pixel_word_nxt;
  logic [REPEAT_W-1:0] repeat_r, repeat_nxt;
  logic                next_data_r;
  status_t             status_r, status_nxt;
  logic                finished_r, finished_nxt;

  // step signals
  logic                in_fire;
  logic                stopped_now;
  logic                stream_ok;
  logic                step_ok;
  logic [BYTE_W-1:0]   b;
  logic [REPEAT_W-1:0] want;
  logic [CNT_W-1:0]    room;
  logic                clipped;
  logic [REPEAT_W-1:0] cnt;

  // decoding stops on the pixel limit or on the input limit the phase needs
  function automatic logic is_stopped(input phase_t ph, input logic [CNT_W-1:0] c_used,
                                      input logic [CNT_W-1:0] d_used,
                                      input logic [CNT_W-1:0] p_written,
                                      input logic [CNT_W-1:0] c_len,
                                      input logic [CNT_W-1:0] d_len,
                                      input logic [CNT_W-1:0] p_lim);
    logic ctrl_out;
    logic data_out;
    logic res;
    ctrl_out = c_used >= c_len;
    data_out = d_used >= d_len;
    if (p_written >= p_lim) begin
      res = 1'b1;
    end else if (ph == PH_LENGTH) begin
      res = ctrl_out;
    end else if (ph == PH_DATA) begin
      res = data_out;
    end else begin
      res = ctrl_out || data_out;
    end
    return res;
  endfunction

  // handshake
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;

  // configuration writes, clamped to the largest legal limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_length_r  <= '0;
      data_length_r     <= '0;
      out_pixel_limit_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CONTROL_LENGTH: begin
          control_length_r <= (cfg_wdata > MAX_STREAM_BYTES) ? MAX_STREAM_BYTES : cfg_wdata;
        end
        REG_DATA_LENGTH: begin
          data_length_r <= (cfg_wdata > MAX_STREAM_BYTES) ? MAX_STREAM_BYTES : cfg_wdata;
        end
        REG_OUT_PIXEL_LIMIT: begin
          out_pixel_limit_r <= (cfg_wdata > MAX_PIXELS) ? MAX_PIXELS : cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  // shared step terms
  assign b           = in_chan.in_byte;
  assign stopped_now = is_stopped(phase_r, control_used_r, data_used_r, pixels_written_r,
                                  control_length_r, data_length_r, out_pixel_limit_r);
  assign stream_ok   = in_chan.from_data_stream == (phase_r == PH_DATA);
  assign step_ok     = !stopped_now && stream_ok;
  assign want        = {1'b0, b} + 9'd1;
  assign room        = (out_pixel_limit_r > pixels_written_r) ?
                       (out_pixel_limit_r - pixels_written_r) : '0;
  assign clipped     = room < {{(CNT_W-REPEAT_W){1'b0}}, want};
  assign cnt         = clipped ? room[REPEAT_W-1:0] : want;

  // next state
  always_comb begin
    phase_nxt          = phase_r;
    run_is_opaque_nxt  = run_is_opaque_r;
    pixels_left_nxt    = pixels_left_r;
    byte_in_pixel_nxt  = byte_in_pixel_r;
    colour_nxt         = colour_r;
    alpha_nxt          = alpha_r;
    control_used_nxt   = control_used_r;
    data_used_nxt      = data_used_r;
    pixels_written_nxt = pixels_written_r;
    if (step_ok) begin
      case (phase_r)
        PH_OPCODE: begin
          control_used_nxt = control_used_r + 25'd1;
          if (b <= 8'd1) begin
            run_is_opaque_nxt = b[0];
            phase_nxt         = PH_LENGTH;
          end else begin
            alpha_nxt         = ~(b - 8'd1);
            pixels_left_nxt   = 9'd1;
            byte_in_pixel_nxt = 2'd0;
            colour_nxt        = '0;
            phase_nxt         = PH_DATA;
          end
        end
        PH_LENGTH: begin
          control_used_nxt = control_used_r + 25'd1;
          if (!run_is_opaque_r) begin
            pixels_written_nxt = pixels_written_r + {{(CNT_W-REPEAT_W){1'b0}}, cnt};
            phase_nxt          = PH_OPCODE;
          end else begin
            alpha_nxt         = ALPHA_OPAQUE;
            pixels_left_nxt   = cnt;
            byte_in_pixel_nxt = 2'd0;
            colour_nxt        = '0;
            phase_nxt         = (cnt != '0) ? PH_DATA : PH_OPCODE;
          end
        end
        PH_DATA: begin
          data_used_nxt = data_used_r + 25'd1;
          case (byte_in_pixel_r)
            2'd0: begin
              colour_nxt        = {8'h00, b};
              byte_in_pixel_nxt = 2'd1;
            end
            2'd1: begin
              colour_nxt        = {b, colour_r[7:0]};
              byte_in_pixel_nxt = 2'd2;
            end
            default: begin
              pixels_written_nxt = pixels_written_r + 25'd1;
              byte_in_pixel_nxt  = 2'd0;
              pixels_left_nxt    = (pixels_left_r != '0) ? pixels_left_r - 9'd1 : '0;
              if (pixels_left_r <= 9'd1) begin
                phase_nxt = PH_OPCODE;
              end
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // result fields
  always_comb begin
    pixel_valid_nxt = 1'b0;
    pixel_word_nxt  = '0;
    repeat_nxt      = '0;
    status_nxt      = ST_OK;
    if (stopped_now) begin
      status_nxt = ST_PAST_LIMIT;
    end else if (!stream_ok) begin
      status_nxt = ST_WRONG_STREAM;
    end else begin
      case (phase_r)
        PH_LENGTH: begin
          if (clipped) begin
            status_nxt = ST_CLIPPED;
          end
          if (!run_is_opaque_r && cnt != '0) begin
            pixel_valid_nxt = 1'b1;
            repeat_nxt      = cnt;
          end
        end
        PH_DATA: begin
          if (byte_in_pixel_r == 2'd2) begin
            pixel_valid_nxt = 1'b1;
            pixel_word_nxt  = {alpha_r, b, colour_r};
            repeat_nxt      = 9'd1;
          end
        end
        default: begin
        end
      endcase
    end
    finished_nxt = is_stopped(phase_nxt, control_used_nxt, data_used_nxt, pixels_written_nxt,
                              control_length_r, data_length_r, out_pixel_limit_r);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_OPCODE;
      run_is_opaque_r  <= 1'b0;
      pixels_left_r    <= '0;
      byte_in_pixel_r  <= '0;
      colour_r         <= '0;
      alpha_r          <= '0;
      control_used_r   <= '0;
      data_used_r      <= '0;
      pixels_written_r <= '0;
    end else if (in_fire) begin
      phase_r          <= phase_nxt;
      run_is_opaque_r  <= run_is_opaque_nxt;
      pixels_left_r    <= pixels_left_nxt;
      byte_in_pixel_r  <= byte_in_pixel_nxt;
      colour_r         <= colour_nxt;
      alpha_r          <= alpha_nxt;
      control_used_r   <= control_used_nxt;
      data_used_r      <= data_used_nxt;
      pixels_written_r <= pixels_written_nxt;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pixel_valid_r <= pixel_valid_nxt;
      pixel_word_r  <= pixel_word_nxt;
      repeat_r      <= repeat_nxt;
      next_data_r   <= (phase_nxt == PH_DATA);
      status_r      <= status_nxt;
      finished_r    <= finished_nxt;
    end
  end

  // result channel
  assign out_chan.valid          = out_valid_r;
  assign out_chan.pixel_valid    = pixel_valid_r;
  assign out_chan.pixel_word     = pixel_word_r;
  assign out_chan.repeat_count   = repeat_r;
  assign out_chan.next_from_data = next_data_r;
  assign out_chan.status         = status_r;
  assign out_chan.finished       = finished_r;

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench of the RGBA run-length decoder. Tagged control and colour bytes
// go in through a bursty valid/ready source, results come back through a
// stalling sink. A behavioral decoder inside the bench predicts each result
// and every returned item is checked field by field against the oldest
// prediction. Directed bytes cover transparent and opaque runs, single pixels,
// wrong-stream bytes and every kind of limit stop; random phases follow, each
// under its own limit setting.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgba_rld_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int PHASE_BYTES  = 100;
  localparam int RANDOM_PHASES = 6;

  typedef struct packed {
    logic              from_data;
    logic [BYTE_W-1:0] value;
  } stream_byte_t;

  typedef struct packed {
    logic                pixel_valid;
    logic [WORD_W-1:0]   pixel_word;
    logic [REPEAT_W-1:0] repeat_count;
    logic                next_from_data;
    status_t             status;
    logic                finished;
  } pixel_result_t;

  logic clk;
  logic rst_n;
  logic              cfg_we;
  logic [ADDR_W-1:0] cfg_addr;
  logic [CNT_W-1:0]  cfg_wdata;

  rgba_rld_in_if  in_chan();
  rgba_rld_out_if out_chan();

  rgba_run_length_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  // pending bytes and predicted results
  stream_byte_t  pending_bytes[$];
  pixel_result_t expected_results[$];
  int            bytes_loaded;
  int            mismatch_count;
  logic          byte_accepted;
  logic          pause_source;

  // source burst and sink stall pattern state
  int burst_left;
  int gap_left;
  int sink_tick;
  int sink_period;
  int sink_stall;
  int idle_cycles;

  // decoder mirror: limits
  logic [CNT_W-1:0] ctrl_limit;
  logic [CNT_W-1:0] data_limit;
  logic [CNT_W-1:0] px_limit;

  // decoder mirror: parse state and counters
  phase_t              dec_phase;
  logic                run_opaque;
  logic [REPEAT_W-1:0] run_left;
  logic [1:0]          byte_idx;
  logic [15:0]         colour_lo;
  logic [BYTE_W-1:0]   alpha_pend;
  logic [CNT_W-1:0]    ctrl_used;
  logic [CNT_W-1:0]    data_used;
  logic [CNT_W-1:0]    px_written;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // stop test of the mirror decoder
  function automatic logic decoder_halted();
    logic ctrl_out;
    logic data_out;
    ctrl_out = ctrl_used >= ctrl_limit;
    data_out = data_used >= data_limit;
    if (px_written >= px_limit) return 1'b1;
    case (dec_phase)
      PH_LENGTH: return ctrl_out;
      PH_DATA:   return data_out;
      default:   return ctrl_out || data_out;
    endcase
  endfunction

  // advance the mirror by one byte and queue the result it should give
  task automatic decode_byte(input logic from_data, input logic [BYTE_W-1:0] b);
    pixel_result_t    r;
    logic [CNT_W-1:0] want;
    logic [CNT_W-1:0] room;
    logic [CNT_W-1:0] cnt;
    r = '0;
    r.status = ST_OK;
    if (decoder_halted()) begin
      r.status = ST_PAST_LIMIT;
    end else if (from_data != (dec_phase == PH_DATA)) begin
      r.status = ST_WRONG_STREAM;
    end else begin
      case (dec_phase)
        PH_OPCODE: begin
          ctrl_used++;
          if (b <= 8'd1) begin
            run_opaque = b[0];
            dec_phase  = PH_LENGTH;
          end else begin
            alpha_pend = ~(b - 8'd1);
            run_left   = 9'd1;
            byte_idx   = 2'd0;
            colour_lo  = '0;
            dec_phase  = PH_DATA;
          end
        end
        PH_LENGTH: begin
          want = {{(CNT_W-BYTE_W){1'b0}}, b} + 25'd1;
          room = (px_limit > px_written) ? px_limit - px_written : '0;
          cnt  = (want < room) ? want : room;
          ctrl_used++;
          if (cnt < want) r.status = ST_CLIPPED;
          if (!run_opaque) begin
            // transparent run leaves as one item
            if (cnt > 0) begin
              r.pixel_valid  = 1'b1;
              r.repeat_count = cnt[REPEAT_W-1:0];
              px_written     = px_written + cnt;
            end
            dec_phase = PH_OPCODE;
          end else begin
            alpha_pend = ALPHA_OPAQUE;
            run_left   = cnt[REPEAT_W-1:0];
            byte_idx   = 2'd0;
            colour_lo  = '0;
            dec_phase  = (cnt > 0) ? PH_DATA : PH_OPCODE;
          end
        end
        default: begin
          data_used++;
          case (byte_idx)
            2'd0: begin
              colour_lo = {8'h00, b};
              byte_idx  = 2'd1;
            end
            2'd1: begin
              colour_lo[15:8] = b;
              byte_idx        = 2'd2;
            end
            default: begin
              r.pixel_valid  = 1'b1;
              r.pixel_word   = {alpha_pend, b, colour_lo};
              r.repeat_count = 9'd1;
              px_written++;
              byte_idx = 2'd0;
              if (run_left > 0) run_left--;
              if (run_left == 0) dec_phase = PH_OPCODE;
            end
          endcase
        end
      endcase
    end
    r.next_from_data = (dec_phase == PH_DATA);
    r.finished       = decoder_halted();
    expected_results.push_back(r);
  endtask

  task automatic check_field(input string field, input logic [31:0] expv, input logic [31:0] actv);
    if (expv !== actv) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, expv, actv);
      mismatch_count++;
    end
  endtask

  // input acceptance feeds the mirror, output acceptance is checked
  always @(posedge clk) begin : monitor
    pixel_result_t got;
    pixel_result_t want;
    if (!rst_n) begin
      byte_accepted <= 1'b0;
    end else begin
      byte_accepted <= in_chan.valid && in_chan.ready;
      if (in_chan.valid && in_chan.ready)
        decode_byte(in_chan.from_data_stream, in_chan.in_byte);
      if (out_chan.valid && out_chan.ready) begin
        got.pixel_valid    = out_chan.pixel_valid;
        got.pixel_word     = out_chan.pixel_word;
        got.repeat_count   = out_chan.repeat_count;
        got.next_from_data = out_chan.next_from_data;
        got.status         = status_t'(out_chan.status);
        got.finished       = out_chan.finished;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result item: expected none, actual word 0x%0h status %0d",
                   $time, got.pixel_word, got.status);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("pixel_valid", 32'(want.pixel_valid), 32'(got.pixel_valid));
          check_field("pixel_word", want.pixel_word, got.pixel_word);
          check_field("repeat_count", 32'(want.repeat_count), 32'(got.repeat_count));
          check_field("next_from_data", 32'(want.next_from_data), 32'(got.next_from_data));
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("finished", 32'(want.finished), 32'(got.finished));
        end
      end
    end
  end

  // byte source: bursts of random length with random gaps
  always @(negedge clk) begin : source_driver
    stream_byte_t nxt;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || byte_accepted) begin
      if (gap_left > 0) begin
        gap_left--;
        in_chan.valid <= 1'b0;
      end else if (!pause_source && pending_bytes.size() > 0) begin
        nxt = pending_bytes.pop_front();
        in_chan.valid            <= 1'b1;
        in_chan.from_data_stream <= nxt.from_data;
        in_chan.in_byte          <= nxt.value;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // result sink: stall windows of random period, some with no stall
  always @(negedge clk) begin : sink_pattern
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= (sink_tick >= sink_stall);
      if (sink_tick + 1 >= sink_period) begin
        sink_tick   = 0;
        sink_period = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 12);
        sink_stall  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, sink_period - 1);
      end else begin
        sink_tick++;
      end
    end
  end

  // watchdog on cycles without progress while work is outstanding
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles = 0;
    end else if (pending_bytes.size() != 0 || in_chan.valid || expected_results.size() != 0) begin
      idle_cycles++;
    end else begin
      idle_cycles = 0;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_byte(input logic from_data, input logic [BYTE_W-1:0] value);
    stream_byte_t s;
    s.from_data = from_data;
    s.value     = value;
    pending_bytes.push_back(s);
    bytes_loaded++;
  endtask

  // three data bytes per pixel, extremes now and then
  task automatic push_colour(input int pixels);
    logic [BYTE_W-1:0] v;
    repeat (3 * pixels) begin
      if ($urandom_range(0, 7) == 0) v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else v = 8'($urandom_range(0, 255));
      push_byte(1'b1, v);
    end
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [CNT_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    // values above the maximum are clamped by the block
    case (idx)
      REG_CONTROL_LENGTH:  ctrl_limit = (value > MAX_STREAM_BYTES) ? MAX_STREAM_BYTES : value;
      REG_DATA_LENGTH:     data_limit = (value > MAX_STREAM_BYTES) ? MAX_STREAM_BYTES : value;
      REG_OUT_PIXEL_LIMIT: px_limit   = (value > MAX_PIXELS) ? MAX_PIXELS : value;
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [CNT_W-1:0] ctrl, input logic [CNT_W-1:0] data,
                            input logic [CNT_W-1:0] pixels);
    write_reg(REG_CONTROL_LENGTH, ctrl);
    write_reg(REG_DATA_LENGTH, data);
    write_reg(REG_OUT_PIXEL_LIMIT, pixels);
  endtask

  // all bytes sent and all results back
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_bytes.size() != 0 || in_chan.valid || expected_results.size() != 0);
  endtask

  // complete whatever sequence the decoder is in the middle of
  task automatic finish_open_sequence();
    case (dec_phase)
      PH_LENGTH: begin
        push_byte(1'b0, 8'h00);
        if (run_opaque) push_colour(1);
      end
      PH_DATA: repeat (3 * run_left - byte_idx) push_byte(1'b1, 8'($urandom_range(0, 255)));
      default: ;
    endcase
  endtask

  // one well-formed sequence most of the time, otherwise noise or a broken pixel
  task automatic push_random_sequence();
    int                pick;
    int                len;
    logic [BYTE_W-1:0] op;
    pick = $urandom_range(0, 99);
    op   = $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 8'hFF : 8'h02)
                                     : 8'($urandom_range(2, 255));
    if (pick < 35) begin
      push_byte(1'b0, 8'h00);
      push_byte(1'b0, 8'($urandom_range(0, 255)));
    end else if (pick < 60) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
      push_byte(1'b0, 8'h01);
      push_byte(1'b0, 8'(len));
      push_colour(len + 1);
    end else if (pick < 85) begin
      push_byte(1'b0, op);
      push_colour(1);
    end else if (pick < 91) begin
      // stray data byte between sequences
      push_byte(1'b1, 8'($urandom_range(0, 255)));
    end else if (pick < 96) begin
      // control byte slipped into a pixel
      push_byte(1'b0, op);
      push_byte(1'b1, 8'($urandom_range(0, 255)));
      push_byte(1'b0, 8'($urandom_range(0, 255)));
      push_byte(1'b1, 8'($urandom_range(0, 255)));
      push_byte(1'b1, 8'($urandom_range(0, 255)));
    end else begin
      // truncated pixel
      push_byte(1'b0, op);
      repeat ($urandom_range(0, 2)) push_byte(1'b1, 8'($urandom_range(0, 255)));
    end
  endtask

  // main sequence
  initial begin
    int target;
    int ph;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = REG_CONTROL_LENGTH;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.from_data_stream = 1'b0;
    in_chan.in_byte = '0;
    out_chan.ready = 1'b0;
    pause_source = 1'b0;
    bytes_loaded = 0;
    mismatch_count = 0;
    burst_left = 1;
    gap_left = 0;
    sink_tick = 0;
    sink_period = 1;
    sink_stall = 0;
    idle_cycles = 0;
    ctrl_limit = '0;
    data_limit = '0;
    px_limit = '0;
    dec_phase = PH_OPCODE;
    run_opaque = 1'b0;
    run_left = '0;
    byte_idx = '0;
    colour_lo = '0;
    alpha_pend = '0;
    ctrl_used = '0;
    data_used = '0;
    px_written = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // zero limits: everything is past the limit
    set_limits('0, '0, '0);
    push_byte(1'b0, 8'h00);
    push_byte(1'b1, 8'hFF);
    wait_idle();

    // largest limits, clamped
    set_limits(25'h1FF_FFFF, 25'h1FF_FFFF, 25'h1FF_FFFF);
    push_byte(1'b1, 8'hFF);                              // data byte where an opcode is due
    push_byte(1'b0, 8'h00); push_byte(1'b0, 8'h00);      // one transparent pixel
    push_byte(1'b0, 8'h00); push_byte(1'b0, 8'hFF);      // 256 transparent pixels
    push_byte(1'b0, 8'h01); push_byte(1'b0, 8'h00);      // opaque run of one
    push_byte(1'b1, 8'h00); push_byte(1'b1, 8'hFF);
    push_byte(1'b0, 8'h5A);                              // control byte inside a pixel
    push_byte(1'b1, 8'hAA);
    push_byte(1'b0, 8'h02);                              // alpha 0xFE
    push_byte(1'b1, 8'hFF); push_byte(1'b1, 8'h00); push_byte(1'b1, 8'h55);
    push_byte(1'b0, 8'hFF);                              // alpha 0x01
    push_byte(1'b1, 8'h12); push_byte(1'b1, 8'h34); push_byte(1'b1, 8'h56);
    wait_idle();

    // transparent run clipped at the pixel limit
    write_reg(REG_OUT_PIXEL_LIMIT, px_written + 25'd3);
    push_byte(1'b0, 8'h00); push_byte(1'b0, 8'h09);
    push_byte(1'b0, 8'h00);
    wait_idle();

    // opaque run clipped at the pixel limit
    write_reg(REG_OUT_PIXEL_LIMIT, px_written + 25'd1);
    push_byte(1'b0, 8'h01); push_byte(1'b0, 8'hFF);
    push_colour(1);
    push_byte(1'b1, 8'h77);
    wait_idle();

    // control bytes run out while a length is due
    set_limits(ctrl_used + 25'd1, 25'h1FF_FFFF, MAX_PIXELS);
    push_byte(1'b0, 8'h00);
    push_byte(1'b0, 8'h05);
    wait_idle();
    write_reg(REG_CONTROL_LENGTH, MAX_STREAM_BYTES);
    push_byte(1'b0, 8'h05);                              // resumes the open run
    wait_idle();

    // data limit lowered below what is used, then data running out in a pixel
    write_reg(REG_DATA_LENGTH, '0);
    push_byte(1'b0, 8'h03);
    wait_idle();
    write_reg(REG_DATA_LENGTH, data_used + 25'd2);
    push_byte(1'b0, 8'h10);
    push_byte(1'b1, 8'hC3); push_byte(1'b1, 8'h3C); push_byte(1'b1, 8'h99);
    wait_idle();

    // random phases, each under its own limits
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: set_limits(25'h1FF_FFFF, 25'h1FF_FFFF, 25'h1FF_FFFF);
        1: set_limits(MAX_STREAM_BYTES, MAX_STREAM_BYTES, MAX_PIXELS);
        2: set_limits(ctrl_used + 25'd4000, data_used + 25'd8000, px_written + 25'd100000);
        3: set_limits(MAX_STREAM_BYTES, MAX_STREAM_BYTES,
                      px_written + 25'($urandom_range(200, 2000)));
        4: set_limits(MAX_STREAM_BYTES, data_used + 25'($urandom_range(60, 200)), MAX_PIXELS);
        default: set_limits(ctrl_used + 25'($urandom_range(40, 120)), MAX_STREAM_BYTES,
                            25'h1FF_FFFF);
      endcase
      finish_open_sequence();
      target = bytes_loaded + PHASE_BYTES;
      while (bytes_loaded < target) push_random_sequence();
      if (ph == 2) begin
        // hold the source until the decoder has drained
        do @(posedge clk); while (pending_bytes.size() > PHASE_BYTES / 2);
        pause_source = 1'b1;
        do @(posedge clk); while (in_chan.valid || expected_results.size() != 0);
        repeat (3) @(posedge clk);
        pause_source = 1'b0;
      end
      wait_idle();
    end

    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- rgba_run_length_decoder.f -----
design/rgba_rld_pkg.sv
design/rgba_rld_in_if.sv
design/rgba_rld_out_if.sv
design/rgba_run_length_decoder.sv
tb/tb.sv
